>>> src/hfc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hfc_pkg
// Shared types and constants of the Hall field conditioner.
// ----------------------------------------------------------------------------
package hfc_pkg;

    localparam int SETTLE_MS       = 500;
    localparam int CAL_WINDOW_MS   = 1000;
    localparam int MAX_CAL_SAMPLES = 4096;
    localparam int CAL_INTERVAL_MS = 2;
    localparam int MIN_CAL_SAMPLES = 16;
    localparam int DIV_STEPS       = 32;

    localparam logic [19:0] LVL_MAX = 20'hFFFFF;
    localparam logic [11:0] ADC_MAX = 12'hFFF;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_SETTLE = 2'd1,
        PH_SAMPLE = 2'd2,
        PH_DONE   = 2'd3
    } phase_t;

    typedef enum logic [2:0] {
        REG_SAMPLE_PERIOD  = 3'd0,
        REG_FILTER_ALPHA   = 3'd1,
        REG_DEADBAND       = 3'd2,
        REG_GAUSS_PER_CNT  = 3'd3,
        REG_TRIGGER_LEVEL  = 3'd4,
        REG_RELEASE_LEVEL  = 3'd5,
        REG_TRIGGER_HOLD   = 3'd6,
        REG_RELEASE_HOLD   = 3'd7
    } reg_index_t;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_UPD  = 7'b0000010,
        S_DIV  = 7'b0000100,
        S_OFF  = 7'b0001000,
        S_MUL  = 7'b0010000,
        S_OVL  = 7'b0100000,
        S_OUT  = 7'b1000000
    } ctrl_state_t;

    typedef struct packed {
        logic latch;
        logic update;
        logic div_step;
        logic div_last;
        logic offset;
        logic mult;
        logic overlay;
        logic load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic div_req;
        logic out_full;
    } dp_status_t;

endpackage

>>> src/hfc_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hfc_in_if / hfc_out_if
// Valid/ready channels for requests and results.
// ----------------------------------------------------------------------------
interface hfc_in_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [31:0] now_ms;
    logic [11:0] adc_sample;

    modport source (output valid, req_type, now_ms, adc_sample, input ready);
    modport sink   (input valid, req_type, now_ms, adc_sample, output ready);
endinterface

interface hfc_out_if;
    logic               valid;
    logic               ready;
    logic               sample_taken;
    logic        [19:0] filtered_value;
    logic        [19:0] zero_level;
    logic signed [20:0] offset_counts;
    logic signed [20:0] field_gauss;
    logic               overlay_on;
    logic        [1:0]  cal_phase;
    logic               cal_valid;
    logic        [11:0] noise_range;

    modport source (output valid, sample_taken, filtered_value, zero_level, offset_counts,
                    field_gauss, overlay_on, cal_phase, cal_valid, noise_range,
                    input ready);
    modport sink   (input valid, sample_taken, filtered_value, zero_level, offset_counts,
                    field_gauss, overlay_on, cal_phase, cal_valid, noise_range,
                    output ready);
endinterface

>>> src/hall_field_conditioner_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hall_field_conditioner_top
// Hall sensor conditioning: median-3, EMA, zero calibration, overlay flag.
// ----------------------------------------------------------------------------
// channel  | dir | contents
// in_ch    | in  | req_type, now_ms, adc_sample
// out_ch   | out | sample_taken .. noise_range, one transaction per request
// cfg      | in  | cfg_we, cfg_index, cfg_data (write only)
//
// a request runs the update, offset, scale, overlay and output states; one that
// closes a calibration window also runs 32 steps of the bit-serial zero divider
// one request is in flight at a time; the next is taken once its result sits
// in the output register, which holds while out_ch.ready is low
// asynchronous active-low reset, no clearing pass
// ----------------------------------------------------------------------------
module hall_field_conditioner_top (
    input  logic        clk,
    input  logic        rst_n,
    hfc_in_if.sink      in_ch,
    hfc_out_if.source   out_ch,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [19:0] cfg_data
);
    import hfc_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;
    logic       ready;

    assign in_ch.ready = ready;

    hfc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (ready),
        .status   (status),
        .cmd      (cmd)
    );

    hfc_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

endmodule

>>> src/hfc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hfc_ctrl
// Sequencer: update, serial divide, offset, scale, overlay, result.
// ----------------------------------------------------------------------------
module hfc_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  hfc_pkg::dp_status_t status,
    output hfc_pkg::dp_cmd_t    cmd
);
    import hfc_pkg::*;

    ctrl_state_t state_reg, state_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        accept;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        cmd.latch  = accept;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                    state_next = S_UPD;
            end
            S_UPD:
            begin
                cmd.update = 1'b1;
                cnt_next   = '0;
                state_next = status.div_req ? S_DIV : S_OFF;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 5'd1;
                if (cnt_reg == 5'(DIV_STEPS - 1))
                begin
                    cmd.div_last = 1'b1;
                    state_next   = S_OFF;
                end
            end
            S_OFF:
            begin
                cmd.offset = 1'b1;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.mult   = 1'b1;
                state_next = S_OVL;
            end
            S_OVL:
            begin
                cmd.overlay = 1'b1;
                state_next  = S_OUT;
            end
            S_OUT:
            begin
                if (!status.out_full)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    a_accept_update: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_UPD))
        else $error("accepted transaction not followed by update");
    a_div_last_only_div: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_last |-> (state_reg == S_DIV) && (cnt_reg == 5'(DIV_STEPS - 1)))
        else $error("divider finished outside divide state");
    a_load_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> !status.out_full && (state_reg == S_OUT))
        else $error("result loaded into full output register");

endmodule

>>> src/hfc_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hfc_datapath
// Filter, calibration, serial divider, field scaling and overlay logic.
// ----------------------------------------------------------------------------
module hfc_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  hfc_pkg::dp_cmd_t    cmd,
    output hfc_pkg::dp_status_t status,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_index,
    input  logic [19:0]         cfg_data,
    hfc_in_if.sink              in_ch,
    hfc_out_if.source           out_ch
);
    import hfc_pkg::*;

    // configuration
    logic [15:0] period_reg;
    logic [8:0]  alpha_reg;
    logic [11:0] deadband_reg;
    logic [15:0] gauss_reg;
    logic [19:0] trig_lvl_reg, rel_lvl_reg;
    logic [15:0] trig_hold_reg, rel_hold_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg    <= 16'd20;
            alpha_reg     <= 9'd64;
            deadband_reg  <= 12'd4;
            gauss_reg     <= 16'd4096;
            trig_lvl_reg  <= 20'd160;
            rel_lvl_reg   <= 20'd80;
            trig_hold_reg <= 16'd200;
            rel_hold_reg  <= 16'd500;
        end
        else if (cfg_we)
        begin
            case (reg_index_t'(cfg_index))
                REG_SAMPLE_PERIOD: period_reg    <= cfg_data[15:0];
                REG_FILTER_ALPHA:  alpha_reg     <= cfg_data[8:0];
                REG_DEADBAND:      deadband_reg  <= cfg_data[11:0];
                REG_GAUSS_PER_CNT: gauss_reg     <= cfg_data[15:0];
                REG_TRIGGER_LEVEL: trig_lvl_reg  <= cfg_data;
                REG_RELEASE_LEVEL: rel_lvl_reg   <= cfg_data;
                REG_TRIGGER_HOLD:  trig_hold_reg <= cfg_data[15:0];
                REG_RELEASE_HOLD:  rel_hold_reg  <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // latched transaction
    logic        req_reg;
    logic [31:0] now_reg;
    logic [11:0] smp_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            req_reg <= in_ch.req_type;
            now_reg <= in_ch.now_ms;
            smp_reg <= in_ch.adc_sample;
        end
    end

    // block state
    logic [31:0] last_reg, pst_reg, tst_reg, rst_reg;
    logic [11:0] med_reg [3];
    logic [1:0]  slot_reg;
    logic [19:0] level_reg;
    logic        seeded_reg;
    phase_t      phase_reg;
    logic [23:0] acc_reg;
    logic [12:0] cnt_reg;
    logic [11:0] low_reg, high_reg;
    logic [19:0] zero_reg;
    logic        zv_reg, ovl_reg, trun_reg, rrun_reg;
    logic        taken_reg, ovl_pend_reg, early_reg;
    logic [31:0] num_reg;
    logic [12:0] den_reg;
    logic [13:0] rem_reg;

    // tick decode
    logic        busy, early, win_end;
    logic [31:0] need, elapsed, ph_elapsed;
    logic [11:0] new_med [3];
    logic [11:0] a0, b0, b1, c1, med;
    logic [8:0]  alpha_eff;
    logic signed [20:0] ema_d;
    logic signed [30:0] ema_p;
    logic signed [22:0] ema_q;
    logic signed [23:0] ema_nl;
    logic [19:0] ema_lvl;
    logic        cnt_ok;
    logic [23:0] acc_new;
    logic [12:0] cnt_new, n_m2;
    logic [11:0] low_new, high_new;
    logic [23:0] sum_trim;

    always_comb
    begin
        busy       = (phase_reg == PH_SETTLE) || (phase_reg == PH_SAMPLE);
        need       = busy ? 32'(CAL_INTERVAL_MS) : {16'd0, period_reg};
        elapsed    = now_reg - last_reg;
        early      = elapsed < need;
        ph_elapsed = now_reg - pst_reg;

        new_med = med_reg;
        new_med[slot_reg] = smp_reg;
        // three compare-exchange steps
        a0  = (new_med[0] > new_med[1]) ? new_med[1] : new_med[0];
        b0  = (new_med[0] > new_med[1]) ? new_med[0] : new_med[1];
        b1  = (b0 > new_med[2]) ? new_med[2] : b0;
        c1  = (b0 > new_med[2]) ? b0 : new_med[2];
        med = (a0 > b1) ? a0 : b1;
        if (c1 < med)
            med = c1;

        alpha_eff = (alpha_reg > 9'd256) ? 9'd256 : alpha_reg;
        ema_d  = $signed({1'b0, med, 8'd0}) - $signed({1'b0, level_reg});
        ema_p  = ema_d * $signed({1'b0, alpha_eff});
        ema_q  = 23'((ema_p + 31'sd128) >>> 8);
        ema_nl = $signed({4'd0, level_reg}) + 24'(ema_q);
        if (ema_nl < 0)
            ema_lvl = '0;
        else if (ema_nl > $signed({4'd0, LVL_MAX}))
            ema_lvl = LVL_MAX;
        else
            ema_lvl = ema_nl[19:0];

        cnt_ok   = cnt_reg < 13'(MAX_CAL_SAMPLES);
        acc_new  = cnt_ok ? acc_reg + {12'd0, smp_reg} : acc_reg;
        cnt_new  = cnt_ok ? cnt_reg + 13'd1 : cnt_reg;
        low_new  = (cnt_ok && smp_reg < low_reg) ? smp_reg : low_reg;
        high_new = (cnt_ok && smp_reg > high_reg) ? smp_reg : high_reg;
        win_end  = (ph_elapsed >= 32'(CAL_WINDOW_MS))
                   && (cnt_new >= 13'(MIN_CAL_SAMPLES));
        sum_trim = acc_new - {12'd0, low_new} - {12'd0, high_new};
        n_m2     = cnt_new - 13'd2;
    end

    assign status.div_req = !req_reg && !early && (phase_reg == PH_SAMPLE) && win_end;

    // divider step
    logic [13:0] rem_sh;
    logic        q_bit;
    logic [31:0] quot;
    assign rem_sh = {rem_reg[12:0], num_reg[31]};
    assign q_bit  = rem_sh >= {1'b0, den_reg};
    assign quot   = {num_reg[30:0], q_bit};

    // offset and field
    logic signed [20:0] diff;
    logic [19:0] mag;
    logic        off_zero;
    logic signed [20:0] off_reg;
    logic [19:0] mag_reg;
    logic        neg_reg;
    logic [36:0] prod;
    logic [20:0] g_raw;
    logic [19:0] g_sat;
    logic [19:0] absg_reg;
    logic signed [20:0] fld_reg;

    assign diff     = $signed({1'b0, level_reg}) - $signed({1'b0, zero_reg});
    assign mag      = diff[20] ? 20'(-diff) : diff[19:0];
    assign off_zero = mag <= {deadband_reg, 8'd0};
    assign prod     = {17'd0, mag_reg} * {21'd0, gauss_reg} + 37'd32768;
    assign g_raw    = prod[36:16];
    assign g_sat    = (g_raw > {1'b0, LVL_MAX}) ? LVL_MAX : g_raw[19:0];

    logic ovl_run;
    assign ovl_run = ovl_pend_reg && (early_reg || (zv_reg && phase_reg == PH_DONE));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reg     <= '0;
            pst_reg      <= '0;
            tst_reg      <= '0;
            rst_reg      <= '0;
            med_reg[0]   <= '0;
            med_reg[1]   <= '0;
            med_reg[2]   <= '0;
            slot_reg     <= '0;
            level_reg    <= '0;
            seeded_reg   <= 1'b0;
            phase_reg    <= PH_IDLE;
            acc_reg      <= '0;
            cnt_reg      <= '0;
            low_reg      <= ADC_MAX;
            high_reg     <= '0;
            zero_reg     <= '0;
            zv_reg       <= 1'b0;
            ovl_reg      <= 1'b0;
            trun_reg     <= 1'b0;
            rrun_reg     <= 1'b0;
            taken_reg    <= 1'b0;
            ovl_pend_reg <= 1'b0;
            early_reg    <= 1'b0;
        end
        else
        begin
            if (cmd.update)
            begin
                if (req_reg)
                begin
                    phase_reg    <= PH_SETTLE;
                    pst_reg      <= now_reg;
                    acc_reg      <= '0;
                    cnt_reg      <= '0;
                    low_reg      <= ADC_MAX;
                    high_reg     <= '0;
                    zv_reg       <= 1'b0;
                    ovl_reg      <= 1'b0;
                    trun_reg     <= 1'b0;
                    rrun_reg     <= 1'b0;
                    taken_reg    <= 1'b0;
                    ovl_pend_reg <= 1'b0;
                    early_reg    <= 1'b0;
                end
                else if (early)
                begin
                    taken_reg    <= 1'b0;
                    early_reg    <= 1'b1;
                    ovl_pend_reg <= !busy && zv_reg;
                end
                else
                begin
                    taken_reg    <= 1'b1;
                    early_reg    <= 1'b0;
                    ovl_pend_reg <= 1'b1;
                    last_reg     <= now_reg;
                    if (!seeded_reg)
                    begin
                        // first sample fills the window and seeds the filter
                        med_reg[0] <= smp_reg;
                        med_reg[1] <= smp_reg;
                        med_reg[2] <= smp_reg;
                        slot_reg   <= 2'd1;
                        level_reg  <= {smp_reg, 8'd0};
                        seeded_reg <= 1'b1;
                    end
                    else
                    begin
                        med_reg   <= new_med;
                        slot_reg  <= (slot_reg == 2'd2) ? 2'd0 : slot_reg + 2'd1;
                        level_reg <= ema_lvl;
                    end
                    if (phase_reg == PH_SETTLE)
                    begin
                        if (ph_elapsed >= 32'(SETTLE_MS))
                        begin
                            phase_reg <= PH_SAMPLE;
                            pst_reg   <= now_reg;
                            acc_reg   <= '0;
                            cnt_reg   <= '0;
                            low_reg   <= ADC_MAX;
                            high_reg  <= '0;
                        end
                    end
                    else if (phase_reg == PH_SAMPLE)
                    begin
                        acc_reg  <= acc_new;
                        cnt_reg  <= cnt_new;
                        low_reg  <= low_new;
                        high_reg <= high_new;
                    end
                end
            end

            if (cmd.div_last)
            begin
                zero_reg  <= (quot > {12'd0, LVL_MAX}) ? LVL_MAX : quot[19:0];
                level_reg <= (quot > {12'd0, LVL_MAX}) ? LVL_MAX : quot[19:0];
                zv_reg    <= 1'b1;
                phase_reg <= PH_DONE;
            end

            if (cmd.overlay && ovl_run)
            begin
                if (!zv_reg)
                    ovl_reg <= 1'b0;
                else if (!ovl_reg)
                begin
                    if (absg_reg >= trig_lvl_reg)
                    begin
                        if (!trun_reg)
                        begin
                            trun_reg <= 1'b1;
                            tst_reg  <= now_reg;
                        end
                        else if ((now_reg - tst_reg) >= {16'd0, trig_hold_reg})
                        begin
                            ovl_reg  <= 1'b1;
                            trun_reg <= 1'b0;
                            rrun_reg <= 1'b0;
                        end
                    end
                    else
                        trun_reg <= 1'b0;
                end
                else
                begin
                    if (absg_reg < rel_lvl_reg)
                    begin
                        if (!rrun_reg)
                        begin
                            rrun_reg <= 1'b1;
                            rst_reg  <= now_reg;
                        end
                        else if ((now_reg - rst_reg) >= {16'd0, rel_hold_reg})
                        begin
                            ovl_reg  <= 1'b0;
                            rrun_reg <= 1'b0;
                            trun_reg <= 1'b0;
                        end
                    end
                    else
                        rrun_reg <= 1'b0;
                end
            end
        end
    end

    // divider, offset and scaling registers
    always_ff @(posedge clk)
    begin
        if (cmd.update)
        begin
            // (sum * 256 + n / 2) / n
            num_reg <= {sum_trim, 8'd0} + {20'd0, n_m2[12:1]};
            den_reg <= n_m2;
            rem_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            num_reg <= quot;
            rem_reg <= q_bit ? rem_sh - {1'b0, den_reg} : rem_sh;
        end
        if (cmd.offset)
        begin
            off_reg <= off_zero ? '0 : diff;
            mag_reg <= off_zero ? '0 : mag;
            neg_reg <= diff[20] && !off_zero;
        end
        if (cmd.mult)
        begin
            absg_reg <= g_sat;
            fld_reg  <= neg_reg ? -$signed({1'b0, g_sat}) : $signed({1'b0, g_sat});
        end
    end

    // output register
    logic out_valid_reg;
    assign status.out_full = out_valid_reg && !out_ch.ready;
    assign out_ch.valid    = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.load_out)
            out_valid_reg <= 1'b1;
        else if (out_ch.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_ch.sample_taken   <= taken_reg;
            out_ch.filtered_value <= level_reg;
            out_ch.zero_level     <= zero_reg;
            out_ch.offset_counts  <= off_reg;
            out_ch.field_gauss    <= fld_reg;
            out_ch.overlay_on     <= ovl_reg;
            out_ch.cal_phase      <= phase_reg;
            out_ch.cal_valid      <= zv_reg;
            out_ch.noise_range    <= (high_reg >= low_reg) ? high_reg - low_reg : '0;
        end
    end

endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the Hall field conditioner: median-3/EMA filter,
// zero calibration, deadband, gauss scaling and the overlay hysteresis flag.
// A directed table runs first, then calibration runs and free ticks under
// four register settings. Every result is compared against an in-bench model.
// ----------------------------------------------------------------------------
module testbench;
    import hfc_pkg::*;

    localparam int CLK_HALF   = 6;
    localparam int STALL_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 60;

    typedef struct packed {
        logic               taken;
        logic        [19:0] filt;
        logic        [19:0] zero;
        logic signed [20:0] offs;
        logic signed [20:0] gauss;
        logic               ovl;
        phase_t             ph;
        logic               zv;
        logic        [11:0] noise;
    } reading_t;

    typedef struct {
        logic        cmd;
        logic [31:0] now;
        logic [11:0] adc;
        logic        typed;
        logic        taken;
        logic [19:0] filt;
        phase_t      ph;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    reg_index_t  cfg_index;
    logic [19:0] cfg_data;

    hfc_in_if  in_ch ();
    hfc_out_if out_ch ();

    hall_field_conditioner_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // register copies
    logic [15:0] period_cfg;
    logic [8:0]  alpha_cfg;
    logic [11:0] deadband_cfg;
    logic [15:0] gauss_cfg;
    logic [19:0] trig_lvl_cfg;
    logic [19:0] rel_lvl_cfg;
    logic [15:0] trig_hold_cfg;
    logic [15:0] rel_hold_cfg;

    // filter and calibration state
    logic [31:0] last_t;
    logic [11:0] med_buf [3];
    logic [1:0]  med_slot;
    logic [1:0]  med_fill;
    logic [19:0] level;
    logic        seeded;
    phase_t      ph;
    logic [31:0] ph_t0;
    logic [23:0] cal_sum;
    logic [12:0] cal_n;
    logic [11:0] cal_lo;
    logic [11:0] cal_hi;
    logic [19:0] zero;
    logic        zv;
    logic        ovl;
    logic        trg_run;
    logic        rel_run;
    logic [31:0] trg_t0;
    logic [31:0] rel_t0;

    reading_t pending_readings [$];
    int       mismatches;
    int       n_sent;
    int       n_checked;
    int       n_taken;
    int       n_cals;
    int       n_ovl_on;
    logic     hold_off_req;
    logic     calm;
    logic     done_sending;

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    task automatic report(input string what, input longint got, input longint want);
        mismatches++;
        $display("mismatch #%0d at %0t: %s got %0d expected %0d",
                 mismatches, $time, what, got, want);
    endtask

    task automatic cal_clear();
        cal_sum = '0;
        cal_n   = '0;
        cal_lo  = ADC_MAX;
        cal_hi  = '0;
    endtask

    function automatic longint offset_now();
        longint d;
        longint mag;
        d   = longint'(level) - longint'(zero);
        mag = (d < 0) ? -d : d;
        return (mag <= longint'(deadband_cfg) * 256) ? 0 : d;
    endfunction

    function automatic longint gauss_now();
        longint d;
        longint mag;
        longint g;
        d   = offset_now();
        mag = (d < 0) ? -d : d;
        g   = (mag * longint'(gauss_cfg) + 32768) >>> 16;
        if (g > longint'(LVL_MAX))
            g = longint'(LVL_MAX);
        return (d < 0) ? -g : g;
    endfunction

    task automatic overlay_step(input logic [31:0] now);
        longint f;
        longint mag;
        f   = gauss_now();
        mag = (f < 0) ? -f : f;
        if (!zv)
            ovl = 1'b0;
        else if (!ovl)
        begin
            if (mag >= longint'(trig_lvl_cfg))
            begin
                if (!trg_run)
                begin
                    trg_run = 1'b1;
                    trg_t0  = now;
                end
                else if (now - trg_t0 >= {16'd0, trig_hold_cfg})
                begin
                    ovl     = 1'b1;
                    trg_run = 1'b0;
                    rel_run = 1'b0;
                    n_ovl_on++;
                end
            end
            else
                trg_run = 1'b0;
        end
        else
        begin
            if (mag < longint'(rel_lvl_cfg))
            begin
                if (!rel_run)
                begin
                    rel_run = 1'b1;
                    rel_t0  = now;
                end
                else if (now - rel_t0 >= {16'd0, rel_hold_cfg})
                begin
                    ovl     = 1'b0;
                    rel_run = 1'b0;
                    trg_run = 1'b0;
                end
            end
            else
                rel_run = 1'b0;
        end
    endtask

    task automatic filter_sample(input logic [11:0] s);
        logic [11:0] a;
        logic [11:0] b;
        logic [11:0] c;
        logic [11:0] t;
        logic [11:0] med;
        longint      w;
        longint      nl;
        if (!seeded)
        begin
            med_buf[0] = s;
            med_buf[1] = s;
            med_buf[2] = s;
            med_slot   = 2'd1;
            med_fill   = 2'd3;
            level      = {s, 8'h00};
            seeded     = 1'b1;
        end
        else
        begin
            med_buf[med_slot] = s;
            med_slot = (med_slot == 2'd2) ? 2'd0 : med_slot + 2'd1;
            if (med_fill < 2'd3)
                med_fill++;
            a = med_buf[0];
            b = med_buf[1];
            c = med_buf[2];
            if (a > b) begin t = a; a = b; b = t; end
            if (b > c) begin t = b; b = c; c = t; end
            if (a > b) begin t = a; a = b; b = t; end
            med = (med_fill < 2'd3) ? s : b;
            w   = (alpha_cfg > 9'd256) ? 256 : longint'(alpha_cfg);
            // floor of (p + 128) / 256 rounds halves toward plus infinity
            nl  = longint'(level) + (((longint'(med) * 256 - longint'(level)) * w + 128) >>> 8);
            if (nl < 0)
                nl = 0;
            if (nl > longint'(LVL_MAX))
                nl = longint'(LVL_MAX);
            level = nl[19:0];
        end
    endtask

    task automatic predict_reading(input logic cmd, input logic [31:0] now,
                                   input logic [11:0] s, output reading_t r);
        logic   taken;
        logic   busy;
        longint sum;
        longint n;
        longint z;
        longint o;
        longint g;
        taken = 1'b0;
        if (cmd)
        begin
            ph      = PH_SETTLE;
            ph_t0   = now;
            cal_clear();
            zv      = 1'b0;
            ovl     = 1'b0;
            trg_run = 1'b0;
            rel_run = 1'b0;
        end
        else
        begin
            busy = (ph == PH_SETTLE) || (ph == PH_SAMPLE);
            if (now - last_t < (busy ? 32'(CAL_INTERVAL_MS) : {16'd0, period_cfg}))
            begin
                if (!busy && zv)
                    overlay_step(now);
            end
            else
            begin
                last_t = now;
                taken  = 1'b1;
                filter_sample(s);
                if (ph == PH_SETTLE)
                begin
                    if (now - ph_t0 >= 32'(SETTLE_MS))
                    begin
                        ph    = PH_SAMPLE;
                        ph_t0 = now;
                        cal_clear();
                    end
                end
                else if (ph == PH_SAMPLE)
                begin
                    if (cal_n < 13'(MAX_CAL_SAMPLES))
                    begin
                        cal_sum += 24'(s);
                        cal_n++;
                        if (s < cal_lo) cal_lo = s;
                        if (s > cal_hi) cal_hi = s;
                    end
                    if (now - ph_t0 >= 32'(CAL_WINDOW_MS) && cal_n >= 13'(MIN_CAL_SAMPLES))
                    begin
                        // trimmed mean: one min and one max dropped
                        sum = longint'(cal_sum) - longint'(cal_lo) - longint'(cal_hi);
                        n   = longint'(cal_n) - 2;
                        z   = (sum * 256 + n / 2) / n;
                        if (z > longint'(LVL_MAX))
                            z = longint'(LVL_MAX);
                        zero  = z[19:0];
                        level = zero;
                        zv    = 1'b1;
                        ph    = PH_DONE;
                        n_cals++;
                    end
                end
                if (zv && ph == PH_DONE)
                    overlay_step(now);
            end
        end
        o       = offset_now();
        g       = gauss_now();
        r.taken = taken;
        r.filt  = level;
        r.zero  = zero;
        r.offs  = o[20:0];
        r.gauss = g[20:0];
        r.ovl   = ovl;
        r.ph    = ph;
        r.zv    = zv;
        r.noise = (cal_hi >= cal_lo) ? cal_hi - cal_lo : 12'd0;
    endtask

    task automatic write_reg(input reg_index_t idx, input logic [19:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            REG_SAMPLE_PERIOD: period_cfg    = val[15:0];
            REG_FILTER_ALPHA:  alpha_cfg     = val[8:0];
            REG_DEADBAND:      deadband_cfg  = val[11:0];
            REG_GAUSS_PER_CNT: gauss_cfg     = val[15:0];
            REG_TRIGGER_LEVEL: trig_lvl_cfg  = val;
            REG_RELEASE_LEVEL: rel_lvl_cfg   = val;
            REG_TRIGGER_HOLD:  trig_hold_cfg = val[15:0];
            REG_RELEASE_HOLD:  rel_hold_cfg  = val[15:0];
            default: ;
        endcase
    endtask

    // returns after the transaction; an optional gap leaves valid low
    task automatic send_request(input logic cmd, input logic [31:0] now,
                                input logic [11:0] s, input logic typed,
                                input reading_t typed_vals);
        reading_t r;
        int       gap;
        in_ch.valid      <= 1'b1;
        in_ch.req_type   <= cmd;
        in_ch.now_ms     <= now;
        in_ch.adc_sample <= s;
        do
            @(posedge clk);
        while (!in_ch.ready);
        predict_reading(cmd, now, s, r);
        if (typed)
        begin
            r.taken = typed_vals.taken;
            r.filt  = typed_vals.filt;
            r.ph    = typed_vals.ph;
        end
        pending_readings.push_back(r);
        n_sent++;
        if (r.taken)
            n_taken++;
        if (n_sent % 100 == 0)
            calm = ($urandom_range(0, 3) == 0);
        gap = 0;
        if (!calm)
        begin
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4: gap = $urandom_range(1, 3);
                5:             gap = $urandom_range(10, 40);
                default:       gap = 0;
            endcase
        end
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain_and_settle();
        in_ch.valid <= 1'b0;
        while (pending_readings.size() != 0)
            @(posedge clk);
        // idle stretch before the register writes
        repeat (45) @(posedge clk);
    endtask

    function automatic logic [11:0] clamp_adc(input int v);
        return (v < 0) ? 12'd0 : (v > 4095) ? ADC_MAX : 12'(v);
    endfunction

    // receiver: random ready, one long hold-off on request
    initial
    begin
        int   stall;
        int   hold;
        logic req_seen;
        stall    = 0;
        hold     = 0;
        req_seen = 1'b0;
        out_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_ch.valid && out_ch.ready)
            begin
                if (pending_readings.size() == 0)
                    report("unexpected transaction", 1, 0);
                else
                begin
                    reading_t e;
                    e = pending_readings.pop_front();
                    n_checked++;
                    if (out_ch.sample_taken !== e.taken)
                        report("sample_taken", out_ch.sample_taken, e.taken);
                    if (out_ch.filtered_value !== e.filt)
                        report("filtered_value", out_ch.filtered_value, e.filt);
                    if (out_ch.zero_level !== e.zero)
                        report("zero_level", out_ch.zero_level, e.zero);
                    if (out_ch.offset_counts !== e.offs)
                        report("offset_counts", out_ch.offset_counts, e.offs);
                    if (out_ch.field_gauss !== e.gauss)
                        report("field_gauss", out_ch.field_gauss, e.gauss);
                    if (out_ch.overlay_on !== e.ovl)
                        report("overlay_on", out_ch.overlay_on, e.ovl);
                    if (out_ch.cal_phase !== e.ph)
                        report("cal_phase", out_ch.cal_phase, e.ph);
                    if (out_ch.cal_valid !== e.zv)
                        report("cal_valid", out_ch.cal_valid, e.zv);
                    if (out_ch.noise_range !== e.noise)
                        report("noise_range", out_ch.noise_range, e.noise);
                end
            end
            // one hold-off per request, taken on its rising edge
            if (hold_off_req && !req_seen)
            begin
                hold     = 400;
                req_seen = 1'b1;
            end
            if (!hold_off_req)
                req_seen = 1'b0;
            if (hold > 0)
            begin
                hold--;
                out_ch.ready <= 1'b0;
            end
            else if (stall > 0)
            begin
                stall--;
                out_ch.ready <= 1'b0;
            end
            else if (calm)
                out_ch.ready <= 1'b1;
            else
            begin
                case ($urandom_range(0, 39))
                    0:             stall = $urandom_range(10, 40);
                    1, 2, 3, 4, 5: stall = $urandom_range(1, 3);
                    default:       stall = 0;
                endcase
                out_ch.ready <= (stall == 0);
            end
        end
    end

    // watchdog on cycles with no transaction on either side
    initial
    begin
        int quiet;
        quiet = 0;
        forever
        begin
            @(posedge clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                quiet = 0;
            else if (rst_n && !done_sending)
                quiet++;
            if (quiet >= STALL_LIMIT)
            begin
                $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
                         quiet, pending_readings.size());
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    initial
    begin
        stim_row_t   rows [$];
        reading_t    tv;
        reading_t    no_typed;
        logic [31:0] now;
        int          center;
        int          spread;
        int          swing;
        int          guard;
        logic [19:0] cfg_sets [4][8];

        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_index        = REG_SAMPLE_PERIOD;
        cfg_data         = '0;
        in_ch.valid      = 1'b0;
        in_ch.req_type   = 1'b0;
        in_ch.now_ms     = '0;
        in_ch.adc_sample = '0;
        hold_off_req     = 1'b0;
        calm             = 1'b0;
        done_sending     = 1'b0;
        no_typed         = '0;
        mismatches = 0; n_sent = 0; n_checked = 0; n_taken = 0; n_cals = 0; n_ovl_on = 0;

        period_cfg = 16'd20; alpha_cfg = 9'd64; deadband_cfg = 12'd4; gauss_cfg = 16'd4096;
        trig_lvl_cfg = 20'd160; rel_lvl_cfg = 20'd80; trig_hold_cfg = 16'd200;
        rel_hold_cfg = 16'd500;
        last_t = '0; med_buf[0] = '0; med_buf[1] = '0; med_buf[2] = '0;
        med_slot = '0; med_fill = '0; level = '0; seeded = 1'b0; ph = PH_IDLE; ph_t0 = '0;
        cal_clear();
        zero = '0; zv = 1'b0; ovl = 1'b0; trg_run = 1'b0; rel_run = 1'b0;
        trg_t0 = '0; rel_t0 = '0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // defaults, low extremes, high extremes, random mix
        cfg_sets[0] = '{20'd20, 20'd64, 20'd4, 20'd4096, 20'd160, 20'd80, 20'd200, 20'd500};
        cfg_sets[1] = '{20'd1, 20'd1, 20'd0, 20'd65535, 20'd0, 20'hFFFFF, 20'd0, 20'd0};
        cfg_sets[2] = '{20'd65535, 20'd511, 20'd4095, 20'd0, 20'hFFFFF, 20'd0,
                        20'd65535, 20'd65535};
        cfg_sets[3] = '{20'd0, 20'd0, 20'($urandom_range(0, 40)), 20'($urandom_range(1, 65535)),
                        20'($urandom_range(0, 4000)), 20'($urandom_range(0, 3000)),
                        20'($urandom_range(0, 100)), 20'($urandom_range(0, 100))};

        // directed table at reset values
        rows = '{
            '{1'b0, 32'd0,   12'd5,     1'b1, 1'b0, 20'h00000, PH_IDLE},
            '{1'b0, 32'd20,  ADC_MAX,   1'b1, 1'b1, 20'hFFF00, PH_IDLE},
            '{1'b0, 32'd39,  12'd0,     1'b1, 1'b0, 20'hFFF00, PH_IDLE},
            '{1'b0, 32'd40,  12'd0,     1'b0, 1'b0, 20'h0,     PH_IDLE},
            '{1'b0, 32'd60,  12'd0,     1'b0, 1'b0, 20'h0,     PH_IDLE},
            '{1'b0, 32'd80,  12'd2048,  1'b0, 1'b0, 20'h0,     PH_IDLE},
            '{1'b1, 32'd100, 12'd0,     1'b0, 1'b0, 20'h0,     PH_SETTLE},
            '{1'b0, 32'd101, 12'h7FF,   1'b0, 1'b0, 20'h0,     PH_IDLE},
            '{1'b0, 32'd102, 12'h800,   1'b0, 1'b0, 20'h0,     PH_IDLE},
            '{1'b0, 32'd600, 12'hAAA,   1'b0, 1'b0, 20'h0,     PH_IDLE},
            '{1'b0, 32'hFFFFFFFF, 12'h555, 1'b0, 1'b0, 20'h0,  PH_IDLE},
            '{1'b1, 32'hFFFFFFF0, 12'hFFF, 1'b0, 1'b0, 20'h0,  PH_SETTLE},
            '{1'b0, 32'h00000004, 12'h001, 1'b0, 1'b0, 20'h0,  PH_IDLE}
        };
        foreach (rows[i])
        begin
            tv       = '0;
            tv.taken = rows[i].taken;
            tv.filt  = rows[i].filt;
            tv.ph    = rows[i].ph;
            send_request(rows[i].cmd, rows[i].now, rows[i].adc, rows[i].typed, tv);
        end

        now = $urandom;
        for (int p = 0; p < 4; p++)
        begin
            drain_and_settle();
            for (int k = 0; k < 8; k++)
                write_reg(reg_index_t'(k), cfg_sets[p][k]);
            @(posedge clk);
            cfg_we <= 1'b0;

            // calibration run with dense ticks, some early or restarted
            center = $urandom_range(200, 3900);
            spread = $urandom_range(0, 60);
            send_request(1'b1, now, 12'($urandom), 1'b0, no_typed);
            guard = 0;
            while (ph != PH_DONE && guard < 3000)
            begin
                guard++;
                if (p == 2 && guard == 40)
                    hold_off_req = 1'b1;
                if (guard == 60)
                    hold_off_req = 1'b0;
                if ($urandom_range(0, 299) == 0)
                    send_request(1'b1, now, 12'($urandom), 1'b0, no_typed);
                now += ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 6);
                send_request(1'b0, now,
                             ($urandom_range(0, 49) == 0) ? 12'($urandom) :
                             clamp_adc(center + $urandom_range(0, 2 * spread) - spread),
                             1'b0, no_typed);
            end

            // free ticks with a field that steps on and off
            swing = 0;
            for (int i = 0; i < 90; i++)
            begin
                if ($urandom_range(0, 24) == 0)
                    swing = ($urandom_range(0, 1) == 0) ? 0 :
                            $urandom_range(0, 3000) - 1500;
                case ($urandom_range(0, 29))
                    0:       now += $urandom;
                    1, 2:    now += $urandom_range(0, 3);
                    default: now += $urandom_range(0, 2 * period_cfg + 2);
                endcase
                if ($urandom_range(0, 99) == 0)
                    send_request(1'b1, now, 12'($urandom), 1'b0, no_typed);
                else
                    send_request(1'b0, now,
                                 ($urandom_range(0, 19) == 0) ? 12'($urandom) :
                                 clamp_adc(center + swing + $urandom_range(0, 8) - 4),
                                 1'b0, no_typed);
            end
        end

        in_ch.valid <= 1'b0;
        while (pending_readings.size() != 0)
            @(posedge clk);
        done_sending = 1'b1;
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d transactions (%0d samples used), %0d zero calibrations",
                 n_checked, n_taken, n_cals);
        $display("four register settings, %0d overlay turn-ons, %0d mismatches",
                 n_ovl_on, mismatches);
        if (mismatches == 0 && pending_readings.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

>>> filelist.f
src/hfc_pkg.sv
src/hfc_if.sv
src/hfc_ctrl.sv
src/hfc_datapath.sv
src/hall_field_conditioner_top.sv
dv/testbench.sv
